[src/pet_pkg.sv]
// Package for the particle emitter: sizes, generator constants, packed vector, particle and register index types.
// Used by the response channel interface, the particle cell, the top level and the testbench.
package pet_pkg;

   localparam int MAX_PARTICLES = 64;
   localparam int CW            = 16;
   localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
   localparam int VEC_W         = 3 * CW;

   localparam logic [31:0] GOLDEN   = 32'h9E37_79B9;
   localparam logic [31:0] RNG_ALT  = 32'hA341_316C;

   typedef logic [2:0][CW-1:0] vec_type;

   typedef struct packed {
      logic [15:0] age;
      vec_type     vel;
      vec_type     pos;
   } cell_type;

   typedef enum logic [2:0] {
      REG_ORIGIN   = 3'd0,
      REG_VEL_LOW  = 3'd1,
      REG_VEL_HIGH = 3'd2,
      REG_GRAVITY  = 3'd3,
      REG_RATE     = 3'd4,
      REG_LIFETIME = 3'd5,
      REG_MAX_LIVE = 3'd6,
      REG_SEED     = 3'd7
   } reg_index_type;

endpackage

[src/pet_if.sv]
// Request and response channel interfaces of the particle emitter.
// Depends on pet_pkg for the live count width.
interface pet_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] delta_time;
   logic        spawn_enable;

   modport source (output valid, delta_time, spawn_enable, input ready);
   modport sink (input valid, delta_time, spawn_enable, output ready);
endinterface

interface pet_rsp_if import pet_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [15:0]      pos_x;
   logic signed [15:0]      pos_y;
   logic signed [15:0]      pos_z;
   logic [15:0]             particle_age;
   logic [CNT_W-1:0]        live_total;
   logic                    particle_valid;
   logic                    last;

   modport source (output valid, pos_x, pos_y, pos_z, particle_age, live_total,
                   particle_valid, last, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, particle_age, live_total,
                 particle_valid, last, output ready);
endinterface

[src/particle_emitter_tick.sv]
// Top level of the particle emitter: sequencer, arithmetic and the particle chain.
// Depends on pet_pkg, pet_if and pet_cell.
// A tick updates the live particles, spawns new ones and then reports every live particle:
// every particle passes the head of the cell chain once for the update (states S_UPD_A and
// S_UPD_B) and once for output, and each spawn draws three random numbers one per cycle
// before it is stored. A response that is held off stalls the output. Requests are taken
// only between ticks. A write of max_live starts a removal pass over the live particles.
module particle_emitter_tick import pet_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pet_req_if.sink           req_ch,
   pet_rsp_if.source         rsp_ch,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_index,
   input  logic [VEC_W-1:0]  csr_write_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_SETUP, S_UPD_A, S_UPD_B, S_CULL, S_SPAWN_CALC, S_DRAW, S_PUSH, S_OUT
   } state_type;

   state_type state_ff;

   vec_type            origin_ff, vlow_ff, vhigh_ff, grav_ff;
   logic [31:0]        rate_ff, seed_ff, rng_ff;
   logic [15:0]        lifetime_ff, frac_ff, dt_ff, agen_ff;
   logic [CNT_W-1:0]   max_live_ff, q_ff, cnt_ff, n_orig_ff, left_ff;
   logic               en_ff;
   logic [47:0]        rdt_ff;
   logic [2:0][24:0]   gdt_ff;
   logic [2:0][41:0]   prod_ff;
   vec_type            vnew_ff;
   logic [1:0]         lane_ff;

   logic               rsp_valid_ff, rsp_pvalid_ff, rsp_last_ff;
   vec_type            rsp_pos_ff;
   logic [15:0]        rsp_age_ff;
   logic [CNT_W-1:0]   rsp_total_ff;

   cell_type           cells [MAX_PARTICLES];
   cell_type           head, push_data;
   logic               pop_en, push_en, emit_go;
   logic [CNT_W-1:0]   wr_idx, cap;
   vec_type            vnew_in, pos_in, spawn_vel;
   logic [2:0][24:0]   gdt_in;
   logic [16:0]        age_sum;
   logic [15:0]        age_in;
   logic [31:0]        rng_in;
   logic [41:0]        prod_in;
   logic [40:0]        total;
   logic [CNT_W-1:0]   room, n_spawn;

   function automatic logic [CW-1:0] sat_lane(input logic signed [25:0] v);
      logic signed [25:0] hi;
      logic signed [25:0] lo;
      hi = 26'((1 << (CW - 1)) - 1);
      lo = -hi - 26'sd1;
      if (v > hi) begin
         sat_lane = hi[CW-1:0];
      end else if (v < lo) begin
         sat_lane = lo[CW-1:0];
      end else begin
         sat_lane = v[CW-1:0];
      end
   endfunction

   assign head    = cells[0];
   assign cap     = (max_live_ff < CNT_W'(MAX_PARTICLES)) ? max_live_ff : CNT_W'(MAX_PARTICLES);
   assign emit_go = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      logic signed [25:0] s;
      logic signed [32:0] p;
      logic signed [32:0] g;
      logic signed [16:0] diff;
      logic signed [18:0] sv;
      rng_in = rng_ff ^ (rng_ff << 13);
      rng_in = rng_in ^ (rng_in >> 17);
      rng_in = rng_in ^ (rng_in << 5);
      diff = 17'(signed'(vhigh_ff[lane_ff])) - 17'(signed'(vlow_ff[lane_ff]));
      prod_in = 42'(diff * signed'({1'b0, rng_in[31:8]}));
      for (int k = 0; k < 3; k++) begin
         g = signed'(grav_ff[k]) * signed'({1'b0, dt_ff});
         gdt_in[k] = 25'(g >>> 8);
         s = 26'(signed'(head.vel[k])) + 26'(signed'(gdt_ff[k]));
         vnew_in[k] = sat_lane(s);
         p = signed'(vnew_ff[k]) * signed'({1'b0, dt_ff});
         s = 26'(signed'(head.pos[k])) + 26'(p >>> 8);
         pos_in[k] = sat_lane(s);
         sv = 19'(signed'(vlow_ff[k])) + 19'(signed'(prod_ff[k]) >>> 24);
         spawn_vel[k] = sv[CW-1:0];
      end
      age_sum = {1'b0, head.age} + {1'b0, dt_ff};
      age_in  = age_sum[16] ? 16'hFFFF : age_sum[15:0];
      total   = 41'(frac_ff) + 41'(rdt_ff[47:8]);
      room    = (cap > q_ff) ? cap - q_ff : '0;
      n_spawn = (total[40:16] < 25'(room)) ? CNT_W'(total[40:16]) : room;

      pop_en    = 1'b0;
      push_en   = 1'b0;
      push_data = head;
      unique case (state_ff)
         S_UPD_B: begin
            pop_en    = 1'b1;
            push_en   = agen_ff < lifetime_ff;
            push_data = '{age: agen_ff, vel: vnew_ff, pos: pos_in};
         end
         S_CULL: begin
            pop_en  = 1'b1;
            push_en = head.age < lifetime_ff;
         end
         S_PUSH: begin
            push_en   = 1'b1;
            push_data = '{age: 16'd0, vel: spawn_vel, pos: origin_ff};
         end
         S_OUT: begin
            pop_en  = emit_go && (q_ff != '0);
            push_en = pop_en;
         end
         default: begin
         end
      endcase
      wr_idx = pop_en ? q_ff - CNT_W'(1) : q_ff;
   end

   for (genvar i = 0; i < MAX_PARTICLES; i++) begin : g_chain
      cell_type nxt;
      if (i == MAX_PARTICLES - 1) begin : g_end
         assign nxt = cells[i];
      end else begin : g_mid
         assign nxt = cells[i+1];
      end
      pet_cell u_cell (
         .clock     (clock),
         .load      (push_en && (wr_idx == CNT_W'(i))),
         .shift     (pop_en),
         .load_data (push_data),
         .next_data (nxt),
         .data      (cells[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         q_ff         <= '0;
         frac_ff      <= '0;
         rng_ff       <= GOLDEN;
         rsp_valid_ff <= 1'b0;
         origin_ff    <= '0;
         vlow_ff      <= '0;
         vhigh_ff     <= '0;
         grav_ff      <= '0;
         rate_ff      <= '0;
         lifetime_ff  <= 16'd256;
         max_live_ff  <= CNT_W'(MAX_PARTICLES);
         seed_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pop_en && !push_en) begin
            q_ff <= q_ff - CNT_W'(1);
         end else if (push_en && !pop_en) begin
            q_ff <= q_ff + CNT_W'(1);
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  dt_ff    <= req_ch.delta_time;
                  en_ff    <= req_ch.spawn_enable;
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               gdt_ff    <= gdt_in;
               rdt_ff    <= rate_ff * dt_ff;
               cnt_ff    <= '0;
               n_orig_ff <= q_ff;
               state_ff  <= (q_ff != '0) ? S_UPD_A : S_SPAWN_CALC;
            end
            S_UPD_A: begin
               vnew_ff  <= vnew_in;
               agen_ff  <= age_in;
               state_ff <= S_UPD_B;
            end
            S_UPD_B: begin
               cnt_ff   <= cnt_ff + CNT_W'(1);
               state_ff <= (cnt_ff + CNT_W'(1) == n_orig_ff) ? S_SPAWN_CALC : S_UPD_A;
            end
            S_CULL: begin
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff + CNT_W'(1) == n_orig_ff) begin
                  state_ff <= S_IDLE;
                  if (push_en) begin
                     q_ff <= (q_ff > cap) ? cap : q_ff;
                  end else begin
                     q_ff <= (q_ff - CNT_W'(1) > cap) ? cap : q_ff - CNT_W'(1);
                  end
               end
            end
            S_SPAWN_CALC: begin
               lane_ff <= 2'd0;
               cnt_ff  <= '0;
               if (en_ff) begin
                  frac_ff <= total[15:0];
               end
               if (en_ff && n_spawn != '0) begin
                  left_ff  <= n_spawn;
                  state_ff <= S_DRAW;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_DRAW: begin
               rng_ff           <= rng_in;
               prod_ff[lane_ff] <= prod_in;
               lane_ff          <= lane_ff + 2'd1;
               if (lane_ff == 2'd2) begin
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               lane_ff  <= 2'd0;
               left_ff  <= left_ff - CNT_W'(1);
               state_ff <= (left_ff == CNT_W'(1)) ? S_OUT : S_DRAW;
            end
            S_OUT: begin
               if (emit_go) begin
                  rsp_valid_ff <= 1'b1;
                  if (q_ff == '0) begin
                     rsp_pos_ff    <= '0;
                     rsp_age_ff    <= '0;
                     rsp_total_ff  <= '0;
                     rsp_pvalid_ff <= 1'b0;
                     rsp_last_ff   <= 1'b1;
                     state_ff      <= S_IDLE;
                  end else begin
                     rsp_pos_ff    <= head.pos;
                     rsp_age_ff    <= head.age;
                     rsp_total_ff  <= q_ff;
                     rsp_pvalid_ff <= 1'b1;
                     rsp_last_ff   <= (cnt_ff == q_ff - CNT_W'(1));
                     cnt_ff        <= cnt_ff + CNT_W'(1);
                     if (cnt_ff == q_ff - CNT_W'(1)) begin
                        state_ff <= S_IDLE;
                     end
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (csr_write_enable) begin
            unique case (reg_index_type'(csr_index))
               REG_ORIGIN:   origin_ff   <= csr_write_data;
               REG_VEL_LOW:  vlow_ff     <= csr_write_data;
               REG_VEL_HIGH: vhigh_ff    <= csr_write_data;
               REG_GRAVITY:  grav_ff     <= csr_write_data;
               REG_RATE:     rate_ff     <= csr_write_data[31:0];
               REG_LIFETIME: lifetime_ff <= csr_write_data[15:0];
               REG_MAX_LIVE: begin
                  max_live_ff <= csr_write_data[CNT_W-1:0];
                  cnt_ff      <= '0;
                  n_orig_ff   <= q_ff;
                  if (q_ff != '0) begin
                     state_ff <= S_CULL;
                  end
               end
               REG_SEED: begin
                  seed_ff  <= csr_write_data[31:0];
                  q_ff     <= '0;
                  frac_ff  <= '0;
                  state_ff <= S_IDLE;
                  rng_ff   <= ((csr_write_data[31:0] ^ GOLDEN) == 32'd0) ?
                              RNG_ALT : (csr_write_data[31:0] ^ GOLDEN);
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.pos_x          = signed'(rsp_pos_ff[0]);
   assign rsp_ch.pos_y          = signed'(rsp_pos_ff[1]);
   assign rsp_ch.pos_z          = signed'(rsp_pos_ff[2]);
   assign rsp_ch.particle_age   = rsp_age_ff;
   assign rsp_ch.live_total     = rsp_total_ff;
   assign rsp_ch.particle_valid = rsp_pvalid_ff;
   assign rsp_ch.last           = rsp_last_ff;

   a_live_capped: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> q_ff <= cap) else $error("live count above cap while idle");
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pvalid_ff |-> rsp_last_ff && rsp_total_ff == '0)
      else $error("empty result malformed");
   a_spawn_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PUSH |-> q_ff < CNT_W'(MAX_PARTICLES)) else $error("spawn into full chain");
   a_out_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pvalid_ff |-> rsp_total_ff != '0) else $error("particle with no live");

endmodule

[src/pet_cell.sv]
// One particle slot of the chain: loads a new particle or takes its neighbor's.
// Depends on pet_pkg for the particle type.
module pet_cell import pet_pkg::*; (
   input  logic     clock,
   input  logic     load,
   input  logic     shift,
   input  cell_type load_data,
   input  cell_type next_data,
   output cell_type data
);

   cell_type data_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end else if (shift) begin
         data_ff <= next_data;
      end
   end

   assign data = data_ff;

endmodule

[test/particle_emitter_checker.sv]
// Checker for the particle emitter: watches the request, response and register ports.
// It keeps its own copy of the particle set and compares every response. Depends on pet_pkg and pet_if.
module particle_emitter_checker import pet_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   pet_req_if               req_mon,
   pet_rsp_if               rsp_mon,
   input  logic             csr_write_enable,
   input  logic [2:0]       csr_index,
   input  logic [VEC_W-1:0] csr_write_data,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
      logic [15:0] age;
      logic [6:0]  live;
      logic        particle_valid;
      logic        last;
   } particle_report;

   particle_report expected_reports[$];

   vec_type     origin, vel_low, vel_high, gravity;
   logic [31:0] rate, seed_value, rng;
   logic [15:0] lifetime, fraction;
   logic [6:0]  max_live;
   int          live;
   vec_type     pos_store[MAX_PARTICLES];
   vec_type     vel_store[MAX_PARTICLES];
   logic [15:0] age_store[MAX_PARTICLES];

   function automatic logic [15:0] saturate(longint v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic int live_cap();
      return (max_live < MAX_PARTICLES) ? int'(max_live) : MAX_PARTICLES;
   endfunction

   task automatic reload_rng();
      rng = seed_value ^ GOLDEN;
      if (rng == 0) rng = RNG_ALT;
   endtask

   task automatic cull_expired();
      int w;
      w = 0;
      for (int r = 0; r < live; r++) begin
         if (age_store[r] < lifetime) begin
            pos_store[w] = pos_store[r];
            vel_store[w] = vel_store[r];
            age_store[w] = age_store[r];
            w++;
         end
      end
      live = w;
   endtask

   function automatic logic [31:0] xorshift(logic [31:0] s);
      s ^= s << 13;
      s ^= s >> 17;
      s ^= s << 5;
      return s;
   endfunction

   task automatic apply_register(logic [2:0] idx, logic [VEC_W-1:0] data);
      case (reg_index_type'(idx))
         REG_ORIGIN: origin = data;
         REG_VEL_LOW: vel_low = data;
         REG_VEL_HIGH: vel_high = data;
         REG_GRAVITY: gravity = data;
         REG_RATE: rate = data[31:0];
         REG_LIFETIME: lifetime = data[15:0];
         REG_MAX_LIVE: begin
            max_live = data[6:0];
            cull_expired();
            if (live > live_cap()) live = live_cap();
         end
         REG_SEED: begin
            seed_value = data[31:0];
            live = 0;
            fraction = 0;
            reload_rng();
         end
         default: ;
      endcase
   endtask

   task automatic advance_tick(logic [15:0] dt, logic enable);
      longint v, total, whole, lo, hi, r, n;
      int unsigned a;
      particle_report rep;
      for (int i = 0; i < live; i++) begin
         for (int k = 0; k < 3; k++) begin
            v = longint'($signed(vel_store[i][k])) +
                ((longint'($signed(gravity[k])) * longint'(dt)) >>> 8);
            vel_store[i][k] = saturate(v);
            v = longint'($signed(pos_store[i][k])) +
                ((longint'($signed(vel_store[i][k])) * longint'(dt)) >>> 8);
            pos_store[i][k] = saturate(v);
         end
         a = age_store[i] + dt;
         age_store[i] = (a > 32'hFFFF) ? 16'hFFFF : a[15:0];
      end
      cull_expired();
      if (enable) begin
         total = longint'(fraction) + ((longint'(rate) * longint'(dt)) >>> 8);
         whole = total >>> 16;
         fraction = total[15:0];
         n = (live >= live_cap()) ? 0 : live_cap() - live;
         if (whole < n) n = whole;
         for (; n > 0; n--) begin
            for (int k = 0; k < 3; k++) begin
               lo = $signed(vel_low[k]);
               hi = $signed(vel_high[k]);
               rng = xorshift(rng);
               r = longint'(rng >> 8);
               pos_store[live][k] = origin[k];
               vel_store[live][k] = saturate(lo + (((hi - lo) * r) >>> 24));
            end
            age_store[live] = 0;
            live++;
         end
      end
      if (live == 0) begin
         rep = '0;
         rep.last = 1'b1;
         expected_reports = {expected_reports, rep};
      end
      for (int i = 0; i < live; i++) begin
         rep.x = pos_store[i][0];
         rep.y = pos_store[i][1];
         rep.z = pos_store[i][2];
         rep.age = age_store[i];
         rep.live = live[6:0];
         rep.particle_valid = 1'b1;
         rep.last = (i + 1 == live);
         expected_reports = {expected_reports, rep};
      end
   endtask

   task automatic check_report();
      particle_report got, want;
      got = '{rsp_mon.pos_x, rsp_mon.pos_y, rsp_mon.pos_z, rsp_mon.particle_age,
              rsp_mon.live_total, rsp_mon.particle_valid, rsp_mon.last};
      if (expected_reports.size() == 0) begin
         $display("%0t: unexpected response %p", $time, got);
         fail_count++;
      end else begin
         want = expected_reports.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
             got.age !== want.age || got.live !== want.live ||
             got.particle_valid !== want.particle_valid || got.last !== want.last) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         origin = '0;
         vel_low = '0;
         vel_high = '0;
         gravity = '0;
         rate = 0;
         lifetime = 16'd256;
         max_live = 7'd64;
         seed_value = 0;
         live = 0;
         fraction = 0;
         fail_count = 0;
         reload_rng();
         expected_reports.delete();
      end else begin
         if (csr_write_enable) apply_register(csr_index, csr_write_data);
         if (req_mon.valid && req_mon.ready)
            advance_tick(req_mon.delta_time, req_mon.spawn_enable);
         if (rsp_mon.valid && rsp_mon.ready) check_report();
      end
      pending = expected_reports.size();
   end
endmodule

[test/tb.sv]
// Top of the particle emitter testbench: clock, reset, register writes, tick requests.
// Response stalls and the verdict live here; checking is done by particle_emitter_checker.
module tb;
   import pet_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_write_enable = 1'b0;
   logic [2:0]       csr_index = '0;
   logic [VEC_W-1:0] csr_write_data = '0;
   logic             hold_rsp = 1'b0;
   int               fail_count, pending;

   pet_req_if req_ch();
   pet_rsp_if rsp_ch();

   particle_emitter_tick DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   particle_emitter_checker checker_inst (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .fail_count(fail_count), .pending(pending)
   );

   always #5 clock = ~clock;

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [VEC_W-1:0] rand_vec(int limit);
      logic [VEC_W-1:0] v;
      if (limit == 0) return VEC_W'({$urandom(), $urandom()});
      for (int k = 0; k < 3; k++)
         v[k*CW +: CW] = CW'($urandom_range(0, 2 * limit) - limit);
      return v;
   endfunction

   task automatic csr_put(reg_index_type idx, logic [VEC_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
   endtask

   task automatic csr_done();
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Waits for every response of the ticks sent so far, then for the block to settle.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic send(logic [15:0] dt, logic enable);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.delta_time <= dt;
      req_ch.spawn_enable <= enable;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      stall = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_rsp <= 1'b0;
         end else if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall = gap_length();
         end
      end
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      logic [15:0] dt;
      req_ch.valid = 1'b0;
      req_ch.delta_time = '0;
      req_ch.spawn_enable = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings spawn nothing, so every tick gives the empty response.
      send(16'h0000, 1'b1);
      send(16'hFFFF, 1'b1);
      send(16'h0100, 1'b0);
      wait_idle();

      // Origin with two lanes at the extremes; a seed that makes the generator state zero.
      csr_put(REG_ORIGIN, {16'h0100, 16'h8000, 16'h7FFF});
      csr_put(REG_VEL_LOW, {16'hF800, 16'hF800, 16'hF800});
      csr_put(REG_VEL_HIGH, {16'h0800, 16'h0800, 16'h0800});
      csr_put(REG_GRAVITY, {16'h0000, 16'hFFC0, 16'h0040});
      csr_put(REG_RATE, VEC_W'(32'h0020_0000));
      csr_put(REG_LIFETIME, VEC_W'(16'h0100));
      csr_put(REG_MAX_LIVE, VEC_W'(7'd64));
      csr_put(REG_SEED, VEC_W'(32'h9E37_79B9));
      csr_done();
      repeat (6) send(16'h0010, 1'b1);
      send(16'h0010, 1'b0);
      send(16'h0000, 1'b1);
      wait_idle();

      // High below low, extreme gravity, a huge rate capped by a max_live above the limit.
      csr_put(REG_VEL_LOW, {16'h7FFF, 16'h0400, 16'h7FFF});
      csr_put(REG_VEL_HIGH, {16'h8000, 16'hFC00, 16'h8000});
      csr_put(REG_GRAVITY, {16'h8000, 16'h7FFF, 16'h8000});
      csr_put(REG_RATE, VEC_W'(32'hFFFF_FFFF));
      csr_put(REG_LIFETIME, VEC_W'(16'hFFFF));
      csr_put(REG_MAX_LIVE, VEC_W'(7'd127));
      csr_done();
      send(16'h0001, 1'b1);
      send(16'h0001, 1'b0);
      wait_idle();
      csr_put(REG_MAX_LIVE, VEC_W'(7'd3));
      csr_done();
      send(16'h0001, 1'b0);
      wait_idle();
      csr_put(REG_LIFETIME, VEC_W'(16'h0000));
      csr_done();
      send(16'h0000, 1'b0);
      wait_idle();
      csr_put(REG_LIFETIME, VEC_W'(16'h0200));
      csr_put(REG_MAX_LIVE, VEC_W'(7'd0));
      csr_done();
      send(16'h0040, 1'b1);
      wait_idle();
      csr_put(REG_MAX_LIVE, VEC_W'(7'd64));
      csr_done();
      send(16'h0040, 1'b1);
      send(16'hFFFF, 1'b0);
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         csr_put(REG_ORIGIN, ($urandom_range(0, 3) == 0) ? rand_vec(0) : rand_vec(2048));
         csr_put(REG_VEL_LOW, ($urandom_range(0, 3) == 0) ? rand_vec(0) : rand_vec(1024));
         csr_put(REG_VEL_HIGH, ($urandom_range(0, 3) == 0) ? rand_vec(0) : rand_vec(1024));
         csr_put(REG_GRAVITY, ($urandom_range(0, 4) == 0) ? rand_vec(0) : rand_vec(64));
         csr_put(REG_RATE, VEC_W'(($urandom_range(0, 5) == 0) ? $urandom() :
                           $urandom_range(32'h0001_0000, 32'h00C0_0000)));
         csr_put(REG_LIFETIME, VEC_W'(($urandom_range(0, 5) == 0) ?
                               $urandom_range(0, 65535) : $urandom_range(64, 1024)));
         if ($urandom_range(0, 1)) csr_put(REG_SEED, VEC_W'($urandom()));
         csr_put(REG_MAX_LIVE, VEC_W'(($urandom_range(0, 5) == 0) ?
                               $urandom_range(0, 127) : $urandom_range(1, 64)));
         csr_done();
         if (phase == 1) hold_rsp <= 1'b1;
         for (int n = 0; n < 22; n++) begin
            dt = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 48));
            send(dt, $urandom_range(0, 4) != 0);
         end
         wait_idle();
      end

      do @(negedge clock); while (pending != 0);
      repeat (200) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
